### design/fpc_pkg.sv
package fpc_pkg;

	localparam int CH_COUNT   = 4;
	localparam int CH_W       = 2;
	localparam int LEN_W      = 15;
	localparam int VAL_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int DIV_STEPS  = 16;
	localparam int CNT_W      = 4;

	localparam logic [BYTE_W-1:0] GRAY_BYTE    = 8'd77;
	localparam logic [BYTE_W-1:0] DENSITY_BYTE = 8'd0;

	// item sequencer states
	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_ANCHOR_START,
		SEQ_ANCHOR_WAIT,
		SEQ_COMMIT,
		SEQ_OUT_START,
		SEQ_OUT_WAIT,
		SEQ_PRESENT
	} seq_state_t;

	// blend unit states
	typedef enum logic [2:0] {
		BU_IDLE,
		BU_MUL_NEW,
		BU_MUL_OLD,
		BU_DIV,
		BU_DONE
	} bu_state_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] new_val;
		logic [VAL_W-1:0] old_val;
		logic [LEN_W-1:0] rem;
		logic [LEN_W-1:0] len;
	} blend_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] result;
	} blend_rsp_t;

endpackage

### design/fog_parameter_crossfader.sv
// An update with a nonzero fade length makes two passes of four channels
// (anchor, then output) through the shared multiply/divide; any other
// transaction makes the output pass only.
// Throughput: one transaction at a time; the next is taken once the result is
// loaded in the output register. Channels with ticks left take 16 divide steps.
// Reset: density 0, colours 77, no fade running.
module fog_parameter_crossfader import fpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [BYTE_W-1:0] density_in,
	input  logic [BYTE_W-1:0] red_in,
	input  logic [BYTE_W-1:0] green_in,
	input  logic [BYTE_W-1:0] blue_in,
	input  logic [LEN_W-1:0]  fade_ticks,
	input  logic              submerged,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VAL_W-1:0]  density_out,
	output logic [BYTE_W-1:0] red_out,
	output logic [BYTE_W-1:0] green_out,
	output logic [BYTE_W-1:0] blue_out,
	output logic              fading
);

	seq_state_t state_q, state_d;
	logic [CH_W-1:0]   ch_q;
	logic              op_q;
	logic              sub_q;
	logic [LEN_W-1:0]  ticks_q;
	logic [BYTE_W-1:0] new_tgt_q [CH_COUNT];
	logic [BYTE_W-1:0] target_q  [CH_COUNT];
	logic [VAL_W-1:0]  snap_q    [CH_COUNT];
	logic [VAL_W-1:0]  cur_q     [CH_COUNT];
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  rem_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  density_q;
	logic [BYTE_W-1:0] red_q, green_q, blue_q;
	logic              fading_q;
	blend_req_t        req;
	blend_rsp_t        rsp;
	logic              accept;
	logic              load_out;
	logic [VAL_W:0]    rnd [CH_COUNT];
	logic [BYTE_W-1:0] col [CH_COUNT];

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != SEQ_IDLE);
	assign load_out = (state_q == SEQ_PRESENT) && (!out_valid_q || !out_stall);

	// drive the shared blend unit with the selected channel
	always_comb begin
		req.start   = (state_q == SEQ_ANCHOR_START) || (state_q == SEQ_OUT_START);
		req.new_val = {target_q[ch_q], BYTE_W'(0)};
		req.old_val = snap_q[ch_q];
		req.rem     = rem_q;
		req.len     = len_q;
	end

	fpc_blend_unit u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// sequence the anchor pass, state update and output pass
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					state_d = (operation && (fade_ticks != '0)) ? SEQ_ANCHOR_START
						: SEQ_COMMIT;
				end
			end
			SEQ_ANCHOR_START: state_d = SEQ_ANCHOR_WAIT;
			SEQ_ANCHOR_WAIT: begin
				if (rsp.done) begin
					state_d = (ch_q == CH_W'(CH_COUNT - 1)) ? SEQ_COMMIT : SEQ_ANCHOR_START;
				end
			end
			SEQ_COMMIT: state_d = SEQ_OUT_START;
			SEQ_OUT_START: state_d = SEQ_OUT_WAIT;
			SEQ_OUT_WAIT: begin
				if (rsp.done) begin
					state_d = (ch_q == CH_W'(CH_COUNT - 1)) ? SEQ_PRESENT : SEQ_OUT_START;
				end
			end
			SEQ_PRESENT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance the channel index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (accept || (state_q == SEQ_COMMIT)) begin
			ch_q <= '0;
		end else if (rsp.done) begin
			ch_q <= ch_q + 1'b1;
		end
	end

	// capture the transaction fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= operation;
			sub_q        <= submerged;
			ticks_q      <= fade_ticks;
			new_tgt_q[0] <= density_in;
			new_tgt_q[1] <= red_in;
			new_tgt_q[2] <= green_in;
			new_tgt_q[3] <= blue_in;
		end
	end

	// hold blend results per channel
	always_ff @(posedge clk) begin
		if (rsp.done) begin
			cur_q[ch_q] <= rsp.result;
		end
	end

	// update fade state: re-anchor, load targets, or count a tick down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q[0] <= DENSITY_BYTE;
			snap_q[0]   <= {DENSITY_BYTE, BYTE_W'(0)};
			for (int i = 1; i < CH_COUNT; i++) begin
				target_q[i] <= GRAY_BYTE;
				snap_q[i]   <= {GRAY_BYTE, BYTE_W'(0)};
			end
			len_q <= '0;
			rem_q <= '0;
		end else if (state_q == SEQ_COMMIT) begin
			if (op_q) begin
				for (int i = 0; i < CH_COUNT; i++) begin
					target_q[i] <= new_tgt_q[i];
					if (ticks_q != '0) begin
						snap_q[i] <= cur_q[i];
					end
				end
				len_q <= ticks_q;
				rem_q <= ticks_q;
			end else if (rem_q != '0) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	// round colours to the nearest byte, saturating
	always_comb begin
		for (int i = 0; i < CH_COUNT; i++) begin
			rnd[i] = (VAL_W+1)'(cur_q[i]) + (VAL_W+1)'(1 << (BYTE_W - 1));
			col[i] = rnd[i][VAL_W] ? {BYTE_W{1'b1}} : rnd[i][VAL_W-1:BYTE_W];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			density_q <= sub_q ? '0 : cur_q[0];
			red_q     <= col[1];
			green_q   <= col[2];
			blue_q    <= col[3];
			fading_q  <= (rem_q != '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign density_out = density_q;
	assign red_out     = red_q;
	assign green_out   = green_q;
	assign blue_out    = blue_q;
	assign fading      = fading_q;

endmodule

### design/fpc_blend_unit.sv
module fpc_blend_unit import fpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  blend_req_t req,
	output blend_rsp_t rsp
);

	bu_state_t state_q, state_d;
	logic [VAL_W-1:0]        rmd_q;
	logic [VAL_W-1:0]        quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [VAL_W-1:0]        mul_a;
	logic [LEN_W-1:0]        mul_b;
	logic [VAL_W+LEN_W-1:0]  prod;
	logic [2*VAL_W-1:0]      acc_sum;
	logic [VAL_W-1:0]        trial;
	logic                    fits;

	// share one multiplier between the two weighted terms
	always_comb begin
		if (state_q == BU_MUL_NEW) begin
			mul_a = req.new_val;
			mul_b = req.len - req.rem;
		end else begin
			mul_a = req.old_val;
			mul_b = req.rem;
		end
		prod = (VAL_W+LEN_W)'(mul_a) * (VAL_W+LEN_W)'(mul_b);
	end

	// accumulate: first term carries the half-divisor rounding offset
	always_comb begin
		if (state_q == BU_MUL_NEW) begin
			acc_sum = (2*VAL_W)'(prod) + (2*VAL_W)'(req.len >> 1);
		end else begin
			acc_sum = {rmd_q, quo_q} + (2*VAL_W)'(prod);
		end
	end

	// one restoring division step
	always_comb begin
		trial = {rmd_q[VAL_W-2:0], quo_q[VAL_W-1]};
		fits  = (trial >= VAL_W'(req.len));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BU_IDLE: begin
				if (req.start) begin
					state_d = (req.rem == '0) ? BU_DONE : BU_MUL_NEW;
				end
			end
			BU_MUL_NEW: state_d = BU_MUL_OLD;
			BU_MUL_OLD: state_d = BU_DIV;
			BU_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = BU_DONE;
				end
			end
			BU_DONE: state_d = BU_IDLE;
			default: state_d = BU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			BU_IDLE: begin
				cnt_q <= '0;
				if (req.start) begin
					quo_q <= req.new_val;
				end
			end
			BU_MUL_NEW, BU_MUL_OLD: begin
				rmd_q <= acc_sum[2*VAL_W-1:VAL_W];
				quo_q <= acc_sum[VAL_W-1:0];
			end
			BU_DIV: begin
				rmd_q <= fits ? (trial - VAL_W'(req.len)) : trial;
				quo_q <= {quo_q[VAL_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign rsp.done   = (state_q == BU_DONE);
	assign rsp.result = quo_q;

endmodule
